FILE: rtl/mesh_group_text_header_parser_defines.svh
// Assertion macros for the group-text header parser.
// Used by rtl/mgth_parse.sv; expects clk_i and rst_ni in scope.
`ifndef MESH_GROUP_TEXT_HEADER_PARSER_DEFINES_SVH
`define MESH_GROUP_TEXT_HEADER_PARSER_DEFINES_SVH

// Check a property at every clock edge out of reset.
`define MGTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies another one in the next clock cycle.
`define MGTH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mgth_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the group-text header parser.
// No dependencies; imported by every module of the block.
package mgth_pkg;

  localparam int MaxPacket = 255;
  localparam int CountW    = $clog2(MaxPacket + 2);
  localparam int PosW      = 10;

  localparam logic [CountW-1:0] CountMax = CountW'(MaxPacket + 1);

  localparam logic [1:0] RouteTransportFlood  = 2'd0;
  localparam logic [1:0] RouteTransportDirect = 2'd3;
  localparam logic [3:0] TypeGroupText        = 4'h5;
  localparam logic [1:0] HashSizeCodeInvalid  = 2'd3;

  localparam logic [PosW-1:0] DescPosPlain     = PosW'(1);
  localparam logic [PosW-1:0] DescPosTransport = PosW'(5);
  localparam logic [PosW-1:0] MinLen           = PosW'(5);
  localparam logic [PosW-1:0] MinLenTransport  = PosW'(6);
  localparam logic [PosW-1:0] MaxPathBytes     = PosW'(64);
  localparam logic [PosW-1:0] MacBytes         = PosW'(2);

  typedef enum logic [2:0] {
    VerdictOk        = 3'd0,
    VerdictShort     = 3'd1,
    VerdictType      = 3'd2,
    VerdictPathDesc  = 3'd3,
    VerdictOverrun   = 3'd4,
    VerdictChannel   = 3'd5,
    VerdictCipherLen = 3'd6,
    VerdictTooLong   = 3'd7
  } verdict_e;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } mgth_item_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              cipher_section;
    logic              packet_done;
    verdict_e          verdict;
    logic [1:0]        route;
    logic [2:0]        hash_len;
    logic [5:0]        hop_count;
    logic [CountW-1:0] packet_length;
  } mgth_result_t;

endpackage

FILE: rtl/mesh_group_text_header_parser.sv
`timescale 1ns / 1ps
// Top level of the group-text header parser: stream ports, config register
// and result register. Depends on mgth_pkg, mgth_in_stage and mgth_parse.
//
// Usage:
//   Input stream s_axis_*: one packet byte per item, tlast on the final byte.
//   Output stream m_axis_*: one item per input byte, the byte echoed with
//   the cipher-section flag in tuser; tlast marks the last byte and then the
//   verdict, route, hash size, hop count and length fields in tdata hold the
//   packet result (they are zero on other items).
//   cfg_we_i/cfg_wdata_i write the expected channel hash; write only while
//   no item is in flight.
// Pipeline: each item goes from s_axis through the input register and then the
// result register to m_axis.
// Throughput: 1 item per cycle while m_axis_tready is high, set by the single
// decode pass between the input register and the result register.
// Reset: clears both pipeline valids, the packet state and the channel hash.
// Stall: when m_axis_tready is low the result holds, the input register
// still fills once, and s_axis_tready then drops until the result is taken.
module mesh_group_text_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] packet_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [10:8] verdict, [12:11] route, [15:13] hash_len,
  // [21:16] hop_count, [30:22] packet_length, [31] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser,  // cipher_section
  output logic        m_axis_tlast,  // packet_done
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import mgth_pkg::*;

  mgth_item_t   in_item, stage_item;
  mgth_result_t result, result_q;
  logic         stage_valid, stage_ready, advance;
  logic         out_valid_q, out_valid_d;
  logic [7:0]   chan_hash_q;

  assign in_item = '{packet_byte: s_axis_tdata, last_byte: s_axis_tlast};

  mgth_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (stage_valid),
    .out_ready_i (stage_ready),
    .out_item_o  (stage_item)
  );

  assign stage_ready = !out_valid_q || m_axis_tready;
  assign advance     = stage_valid && stage_ready;

  mgth_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (stage_item),
    .chan_hash_i (chan_hash_q),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (stage_ready) begin
      out_valid_d = stage_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      chan_hash_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        chan_hash_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result_q.cipher_section;
  assign m_axis_tlast  = result_q.packet_done;
  assign m_axis_tdata  = {1'b0, 9'(result_q.packet_length), result_q.hop_count,
                          result_q.hash_len, result_q.route, result_q.verdict,
                          result_q.data_byte};

endmodule

FILE: rtl/mgth_in_stage.sv
`timescale 1ns / 1ps
// Input register stage of the group-text header parser.
// Depends on mgth_pkg for the item type.
module mgth_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mgth_pkg::mgth_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mgth_pkg::mgth_item_t out_item_o
);
  import mgth_pkg::*;

  logic       valid_q, valid_d;
  mgth_item_t item_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

FILE: rtl/mgth_parse.sv
`timescale 1ns / 1ps
// Packet state and header decode of the group-text header parser.
// Depends on mgth_pkg and the assertion macros in the defines header.
`include "mesh_group_text_header_parser_defines.svh"
module mgth_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  mgth_pkg::mgth_item_t  item_i,
  input  logic [7:0]            chan_hash_i,
  output mgth_pkg::mgth_result_t result_o
);
  import mgth_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        header_q, header_d;
  logic [7:0]        desc_q, desc_d;
  logic [7:0]        chan_q, chan_d;

  logic [7:0]        b;
  logic [PosW-1:0]   p, n_pos, dpos, cpos, rem, rem_mac;
  logic [CountW-1:0] n;
  logic [7:0]        hdr, desc, chan;
  logic [1:0]        route;
  logic [3:0]        ptype;
  logic              transport, valid, capture, cipher, type_ok;
  logic [2:0]        hs;
  logic [5:0]        hc;
  logic [8:0]        path_len;
  verdict_e          verdict;

  always_comb begin
    b          = item_i.packet_byte;
    p          = PosW'(count_q);
    hdr        = (count_q == '0) ? b : header_q;
    route      = hdr[1:0];
    ptype      = hdr[5:2];
    type_ok    = ptype == TypeGroupText;
    transport  = route == RouteTransportFlood || route == RouteTransportDirect;
    dpos       = transport ? DescPosTransport : DescPosPlain;
    desc       = (p == dpos) ? b : desc_q;
    hs         = {1'b0, desc[7:6]} + 3'd1;
    hc         = desc[5:0];
    path_len   = 9'(hs) * 9'(hc);
    valid      = desc[7:6] != HashSizeCodeInvalid && PosW'(path_len) <= MaxPathBytes;
    cpos       = dpos + PosW'(1) + PosW'(path_len);
    chan       = (p == cpos) ? b : chan_q;
    capture    = count_q <= CountW'(MaxPacket);
    n          = (count_q == CountMax) ? count_q : count_q + CountW'(1);
    n_pos      = PosW'(n);
    cipher     = p > dpos && p > cpos && type_ok && valid;
    rem        = n_pos - cpos - PosW'(1);
    rem_mac    = rem - MacBytes;
  end

  always_comb begin
    if (n > CountW'(MaxPacket)) begin
      verdict = VerdictTooLong;
    end else if (n_pos < MinLen) begin
      verdict = VerdictShort;
    end else if (!type_ok) begin
      verdict = VerdictType;
    end else if (transport && n_pos < MinLenTransport) begin
      verdict = VerdictShort;
    end else if (dpos >= n_pos) begin
      verdict = VerdictShort;
    end else if (!valid) begin
      verdict = VerdictPathDesc;
    end else if (cpos >= n_pos) begin
      verdict = VerdictOverrun;
    end else if (chan != chan_hash_i) begin
      verdict = VerdictChannel;
    end else if (rem <= MacBytes || rem_mac[3:0] != 4'd0) begin
      verdict = VerdictCipherLen;
    end else begin
      verdict = VerdictOk;
    end
  end

  always_comb begin
    result_o                = '0;
    result_o.data_byte      = b;
    result_o.cipher_section = cipher;
    if (item_i.last_byte) begin
      result_o.packet_done   = 1'b1;
      result_o.verdict       = verdict;
      result_o.route         = route;
      result_o.hash_len      = hs;
      result_o.hop_count     = hc;
      result_o.packet_length = n;
    end
  end

  always_comb begin
    count_d  = n;
    header_d = header_q;
    desc_d   = desc_q;
    chan_d   = chan_q;
    if (capture) begin
      if (count_q == '0) header_d = b;
      if (p == dpos) desc_d = b;
      if (p == cpos) chan_d = b;
    end
    if (item_i.last_byte) begin
      count_d  = '0;
      header_d = '0;
      desc_d   = '0;
      chan_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      header_q <= '0;
      desc_q   <= '0;
      chan_q   <= '0;
    end else if (advance_i) begin
      count_q  <= count_d;
      header_q <= header_d;
      desc_q   <= desc_d;
      chan_q   <= chan_d;
    end
  end

  `MGTH_ASSERT(a_count_range, count_q <= CountMax, "byte count past saturation")
  `MGTH_ASSERT_NEXT(a_clear_on_last, advance_i && item_i.last_byte, count_q == '0,
                    "byte count not cleared after last item")
  `MGTH_ASSERT_NEXT(a_count_step, advance_i && !item_i.last_byte && count_q != CountMax,
                    count_q == $past(count_q) + CountW'(1), "byte count did not advance")
  `MGTH_ASSERT(a_quiet_mid, !item_i.last_byte |-> result_o.packet_length == '0 &&
               result_o.verdict == VerdictOk, "verdict fields set before last item")

endmodule
